// ----- sv/strongly_connected_components_assert.svh -----
// assertion macros for the strongly connected components block
// no dependencies
`ifndef STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_ASSERT_SVH

// same-cycle implication
`define SCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc assertion failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc assertion failed");

`endif

// ----- sv/scc_pkg.sv -----
// package for the strongly connected components block
// request and result types, sizes and command codes; no dependencies
package scc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int VTX_W            = 6;
    localparam int CNT_W            = 7;
    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd1;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_SOLVE    = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic [CNT_W-1:0] component_label;
        logic [CNT_W-1:0] component_total;
        logic             last;
    } t_out_item;

endpackage

// ----- sv/scc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/strongly_connected_components.sv -----
// edge load: accepted while idle, next request the following cycle
// solve: each edge scanned is an edge ram read then a check; every vertex scans the edge list
//   once per pass, then a sweep of the owner ram in reverse finish order drives the second pass
// results: one per vertex, each read, loaded, then held until taken; input stalls until the last
// sync active-low reset clears fsm, graph and valid state; solve clears the graph afterwards
// uses scc_pkg, scc_ram and strongly_connected_components_assert.svh
module strongly_connected_components #(
    parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = scc_pkg::MAX_EDGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [scc_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  scc_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output scc_pkg::t_out_item           o_out_data
);

`include "strongly_connected_components_assert.svh"

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int DW  = $clog2(MAX_VERTICES + 1);
    localparam int TW  = $clog2(2 * MAX_VERTICES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EFW = $clog2(MAX_EDGES + 1);
    localparam int CW  = scc_pkg::CNT_W;
    localparam int SW  = VW + EFW;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_ROOT     = 13'b0000000000010,
        S_FW_RD    = 13'b0000000000100,
        S_FW_CHK   = 13'b0000000001000,
        S_FW_POP   = 13'b0000000010000,
        S_RK_RD    = 13'b0000000100000,
        S_RK_CHK   = 13'b0000001000000,
        S_SP_RD    = 13'b0000010000000,
        S_SP_CHK   = 13'b0000100000000,
        S_SP_POP   = 13'b0001000000000,
        S_OUT_RD   = 13'b0010000000000,
        S_OUT_LD   = 13'b0100000000000,
        S_OUT_WAIT = 13'b1000000000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_vcount;
    logic [EFW-1:0]         r_fill, n_fill;
    logic [MAX_VERTICES-1:0]     r_visited, n_visited;
    logic [MAX_VERTICES-1:0]     r_labelled, n_labelled;
    logic [2*MAX_VERTICES-1:0]   r_own_vld, n_own_vld;
    logic [TW:0]            r_tick, n_tick;
    logic [CW-1:0]          r_lcount, n_lcount;
    logic [CW-1:0]          r_root, n_root;
    logic [VW-1:0]          r_v, n_v;
    logic [EFW-1:0]         r_e, n_e;
    logic [DW-1:0]          r_depth, n_depth;
    logic [TW-1:0]          r_t, n_t;
    logic [VW-1:0]          r_out, n_out;
    logic                   r_oval, n_oval;
    scc_pkg::t_out_item     r_odata, n_odata;

    logic [CW-1:0]          n_act;
    logic [DW-1:0]          depth_m1, depth_m2;
    logic                   t_done;

    logic                   edge_we;
    logic [EAW-1:0]         edge_raddr;
    logic [2*VW-1:0]        edge_wdata, edge_rdata;
    logic [VW-1:0]          e_tail, e_head;

    logic                   stk_we;
    logic [VW-1:0]          stk_waddr, stk_raddr;
    logic [SW-1:0]          stk_wdata, stk_rdata;

    logic                   own_we;
    logic [TW-1:0]          own_raddr;
    logic [VW-1:0]          own_rdata;

    logic                   lab_we;
    logic [VW-1:0]          lab_waddr, lab_raddr;
    logic [CW-1:0]          lab_wdata, lab_rdata;

    logic                   last_fire;
    logic                   graph_clear;

    scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(r_fill[EAW-1:0]), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );

    scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES), .AW(VW)) u_stack_ram (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    scc_ram #(.WIDTH(VW), .DEPTH(2*MAX_VERTICES), .AW(TW)) u_owner_ram (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(r_tick[TW-1:0]), .i_wdata(r_v),
        .i_raddr(own_raddr), .o_rdata(own_rdata)
    );

    scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES), .AW(VW)) u_label_ram (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rdata)
    );

    assign e_tail   = edge_rdata[2*VW-1:VW];
    assign e_head   = edge_rdata[VW-1:0];
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    always_comb begin
        if (r_vcount == '0) begin
            n_act = CW'(1);
        end else if (r_vcount > CW'(MAX_VERTICES)) begin
            n_act = CW'(MAX_VERTICES);
        end else begin
            n_act = r_vcount;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_visited  = r_visited;
        n_labelled = r_labelled;
        n_own_vld  = r_own_vld;
        n_tick     = r_tick;
        n_lcount   = r_lcount;
        n_root     = r_root;
        n_v        = r_v;
        n_e        = r_e;
        n_depth    = r_depth;
        n_t        = r_t;
        n_out      = r_out;
        n_oval     = r_oval;
        n_odata    = r_odata;
        t_done     = 1'b0;
        edge_we    = 1'b0;
        edge_wdata = {VW'(i_in_data.from_vertex), VW'(i_in_data.to_vertex)};
        edge_raddr = r_e[EAW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = depth_m1[VW-1:0];
        stk_wdata  = {r_v, r_e + EFW'(1)};
        stk_raddr  = depth_m1[VW-1:0];
        own_we     = 1'b0;
        own_raddr  = r_t;
        lab_we     = 1'b0;
        lab_waddr  = e_tail;
        lab_wdata  = r_lcount;
        lab_raddr  = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd == scc_pkg::CMD_SOLVE) begin
                        n_root  = '0;
                        n_state = S_ROOT;
                    end else if (CW'(i_in_data.from_vertex) < n_act &&
                                 CW'(i_in_data.to_vertex) < n_act &&
                                 r_fill < EFW'(MAX_EDGES)) begin
                        edge_we = 1'b1;
                        n_fill  = r_fill + EFW'(1);
                    end
                end
            end
            S_ROOT: begin
                if (r_root == n_act) begin
                    n_t     = TW'(2 * MAX_VERTICES - 1);
                    n_state = S_RK_RD;
                end else if (r_visited[r_root[VW-1:0]]) begin
                    n_root = r_root + CW'(1);
                end else begin
                    n_visited[r_root[VW-1:0]] = 1'b1;
                    n_tick  = r_tick + (TW+1)'(1);
                    n_v     = r_root[VW-1:0];
                    n_e     = '0;
                    n_depth = DW'(1);
                    n_state = S_FW_RD;
                end
            end
            S_FW_RD: begin
                if (r_e >= r_fill) begin
                    // vertex finishes
                    own_we = 1'b1;
                    n_own_vld[r_tick[TW-1:0]] = 1'b1;
                    n_tick  = r_tick + (TW+1)'(1);
                    n_depth = depth_m1;
                    if (r_depth == DW'(1)) begin
                        n_root  = r_root + CW'(1);
                        n_state = S_ROOT;
                    end else begin
                        stk_raddr = depth_m2[VW-1:0];
                        n_state   = S_FW_POP;
                    end
                end else begin
                    n_state = S_FW_CHK;
                end
            end
            S_FW_CHK: begin
                n_e     = r_e + EFW'(1);
                n_state = S_FW_RD;
                if (e_tail == r_v && CW'(e_head) < n_act && !r_visited[e_head]) begin
                    stk_we = 1'b1;
                    n_visited[e_head] = 1'b1;
                    n_tick  = r_tick + (TW+1)'(1);
                    n_v     = e_head;
                    n_e     = '0;
                    n_depth = r_depth + DW'(1);
                end
            end
            S_FW_POP: begin
                n_v     = stk_rdata[SW-1:EFW];
                n_e     = stk_rdata[EFW-1:0];
                n_state = S_FW_RD;
            end
            S_RK_RD: begin
                if (r_own_vld[r_t]) begin
                    n_state = S_RK_CHK;
                end else begin
                    t_done = 1'b1;
                end
            end
            S_RK_CHK: begin
                if (!r_labelled[own_rdata]) begin
                    n_lcount  = r_lcount + CW'(1);
                    lab_we    = 1'b1;
                    lab_waddr = own_rdata;
                    lab_wdata = r_lcount + CW'(1);
                    n_labelled[own_rdata] = 1'b1;
                    n_v     = own_rdata;
                    n_e     = '0;
                    n_depth = '0;
                    n_state = S_SP_RD;
                end else begin
                    t_done = 1'b1;
                end
            end
            S_SP_RD: begin
                if (r_e >= r_fill) begin
                    if (r_depth == '0) begin
                        t_done = 1'b1;
                    end else begin
                        n_depth = depth_m1;
                        n_state = S_SP_POP;
                    end
                end else begin
                    n_state = S_SP_CHK;
                end
            end
            S_SP_CHK: begin
                n_e     = r_e + EFW'(1);
                n_state = S_SP_RD;
                if (e_head == r_v && CW'(e_tail) < n_act && !r_labelled[e_tail]) begin
                    lab_we    = 1'b1;
                    n_labelled[e_tail] = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = r_depth[VW-1:0];
                    stk_wdata = {e_tail, EFW'(0)};
                    n_depth   = r_depth + DW'(1);
                end
            end
            S_SP_POP: begin
                n_v     = stk_rdata[SW-1:EFW];
                n_e     = '0;
                n_state = S_SP_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_odata.vertex_index    = scc_pkg::VTX_W'(r_out);
                n_odata.component_label = lab_rdata;
                n_odata.component_total = r_lcount;
                n_odata.last            = (CW'(r_out) + CW'(1) == n_act);
                n_oval  = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (!i_out_stall) begin
                    n_oval = 1'b0;
                    if (r_odata.last) begin
                        n_fill     = '0;
                        n_visited  = '0;
                        n_labelled = '0;
                        n_own_vld  = '0;
                        n_tick     = '0;
                        n_lcount   = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_out   = r_out + VW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (t_done) begin
            if (r_t == '0) begin
                n_out   = '0;
                n_state = S_OUT_RD;
            end else begin
                n_t     = r_t - TW'(1);
                n_state = S_RK_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= scc_pkg::VCOUNT_RESET;
            r_fill     <= '0;
            r_visited  <= '0;
            r_labelled <= '0;
            r_own_vld  <= '0;
            r_tick     <= '0;
            r_lcount   <= '0;
            r_depth    <= '0;
            r_oval     <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            r_fill     <= n_fill;
            r_visited  <= n_visited;
            r_labelled <= n_labelled;
            r_own_vld  <= n_own_vld;
            r_tick     <= n_tick;
            r_lcount   <= n_lcount;
            r_depth    <= n_depth;
            r_oval     <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root  <= n_root;
        r_v     <= n_v;
        r_e     <= n_e;
        r_t     <= n_t;
        r_out   <= n_out;
        r_odata <= n_odata;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_data  = r_odata;

    assign last_fire   = o_out_valid && !i_out_stall && o_out_data.last;
    assign graph_clear = (r_fill == '0) && (r_lcount == '0) && (r_visited == '0);

    `SCC_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, r_oval, o_in_stall)
    `SCC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, last_fire, graph_clear)
    `SCC_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(MAX_VERTICES))

endmodule
